// ===== design/direct_dft_engine_assert.svh =====
// Assertion macros shared by the direct DFT engine RTL.
`ifndef DIRECT_DFT_ENGINE_ASSERT_SVH
`define DIRECT_DFT_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DDE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dde_pkg.sv =====
// Shared constants, types and the twiddle table of the direct DFT engine.
package dde_pkg;

  localparam int MaxPointsDef   = 64;
  localparam int SampleWidthDef = 16;

  // Twiddle table: 64 phase steps per turn, 1.0 is exactly 32768.
  localparam int RomPoints  = 64;
  localparam int PhaseW     = 6;
  localparam int QuarterPts = RomPoints / 4;
  localparam int TwW        = 17;
  localparam int TwFrac     = 15;

  localparam int OutW    = 24;
  localparam int BinIdxW = 6;
  localparam int OutMax  = 8388607;
  localparam int OutMin  = -8388608;

  localparam int LenW     = 3;
  localparam int MinLog2  = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 3;

  localparam logic [CfgIdxW-1:0] CFG_INVERSE_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOG2_POINTS  = 2'd1;

  localparam logic [TwW-1:0] QuarterCos [QuarterPts+1] = '{
    17'd32768, 17'd32610, 17'd32138, 17'd31357, 17'd30274, 17'd28899,
    17'd27246, 17'd25330, 17'd23170, 17'd20788, 17'd18205, 17'd15447,
    17'd12540, 17'd9512,  17'd6393,  17'd3212,  17'd0
  };

  // Cosine over a full turn, built from the first quadrant by symmetry.
  function automatic logic signed [TwW-1:0] tw_cos(input logic [PhaseW-1:0] m);
    logic [PhaseW:0] mx;
    logic [PhaseW:0] idx;
    logic            neg;
    logic signed [TwW-1:0] mag;
    mx = {1'b0, m};
    if (mx <= (PhaseW+1)'(QuarterPts)) begin
      idx = mx;
      neg = 1'b0;
    end else if (mx <= (PhaseW+1)'(2*QuarterPts)) begin
      idx = (PhaseW+1)'(2*QuarterPts) - mx;
      neg = 1'b1;
    end else if (mx <= (PhaseW+1)'(3*QuarterPts)) begin
      idx = mx - (PhaseW+1)'(2*QuarterPts);
      neg = 1'b1;
    end else begin
      idx = (PhaseW+1)'(RomPoints) - mx;
      neg = 1'b0;
    end
    mag = signed'(QuarterCos[idx[4:0]]);
    return neg ? -mag : mag;
  endfunction

endpackage

// ===== design/dde_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dde_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/direct_dft_engine.sv =====
// Direct DFT engine: collects a frame of complex samples and emits every bin by direct sum.
//
// Samples are taken one per cycle until the frame of N = 2^log2_points
// entries is full; the block then stops taking samples and computes the bins
// k = 0..N-1 in order with one shared complex multiply-accumulate unit that
// handles one sample-twiddle product per cycle. Each bin accumulates N
// products, then passes through pipeline drain, rounding and output load;
// a stalled output holds the sequencer in rounding until the output is free.
// The last bin of a frame may still wait on the output while the next
// frame starts loading. Forward mode scales by 1/N, inverse mode uses the
// conjugate twiddle and does not scale; results are rounded half up and
// saturated to 24 bits.
module direct_dft_engine #(
  parameter int MAX_POINTS   = dde_pkg::MaxPointsDef,
  parameter int SAMPLE_WIDTH = dde_pkg::SampleWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dde_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [dde_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_real_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_imag_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [dde_pkg::OutW-1:0]   bin_real_o,
  output logic signed [dde_pkg::OutW-1:0]   bin_imag_o,
  output logic [dde_pkg::BinIdxW-1:0]       bin_index_o,
  output logic                              last_bin_o
);

  import dde_pkg::*;

  `include "direct_dft_engine_assert.svh"

  localparam int AddrW   = $clog2(MAX_POINTS);
  localparam int CntW    = AddrW + 1;
  localparam int MaxLog2 = ($clog2(MAX_POINTS + 1) - 1 > 6) ? 6 : $clog2(MAX_POINTS + 1) - 1;
  localparam int ProdW   = SAMPLE_WIDTH + TwW;
  localparam int AccW    = SAMPLE_WIDTH + TwW + 1 + AddrW;
  localparam int ShW     = 5;

  localparam logic signed [AccW-1:0] SatHi = AccW'(OutMax);
  localparam logic signed [AccW-1:0] SatLo = AccW'(OutMin);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN,
    ST_ROUND
  } state_e;

  // Configuration registers.
  logic            inverse_q;
  logic [LenW-1:0] log2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inverse_q <= 1'b0;
      log2_q    <= LenW'(6);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_INVERSE_MODE: inverse_q <= cfg_data_i[0];
        CFG_LOG2_POINTS:  log2_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame length in use, clamped to at least 4 points and to what the frame store can hold.
  logic [LenW-1:0]   l_act;
  logic [CntW-1:0]   n_pts;
  logic [PhaseW-1:0] stride;
  logic [ShW-1:0]    sh_amt;

  always_comb begin
    if (log2_q < LenW'(MinLog2)) begin
      l_act = LenW'(MinLog2);
    end else if (log2_q > LenW'(MaxLog2)) begin
      l_act = LenW'(MaxLog2);
    end else begin
      l_act = log2_q;
    end
  end

  assign n_pts  = CntW'(1) << l_act;
  assign stride = PhaseW'((PhaseW+1)'(RomPoints) >> l_act);
  assign sh_amt = ShW'(TwFrac) + (inverse_q ? ShW'(0) : ShW'(l_act));

  // Sequencer state.
  state_e            state_q;
  logic [AddrW-1:0]  load_q;
  logic [AddrW-1:0]  k_q;
  logic [AddrW-1:0]  j_q;
  logic [PhaseW-1:0] phase_q;
  logic [PhaseW-1:0] step_q;
  logic              out_valid_q;
  logic              out_last_q;
  logic [BinIdxW-1:0] out_idx_q;
  logic signed [OutW-1:0] out_re_q;
  logic signed [OutW-1:0] out_im_q;

  logic in_fire;
  logic frame_done;
  logic j_last;
  logic k_last;
  logic out_free;
  logic done_q;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign frame_done = ({1'b0, load_q} + CntW'(1)) >= n_pts;
  assign j_last     = {1'b0, j_q} == (n_pts - CntW'(1));
  assign k_last     = {1'b0, k_q} == (n_pts - CntW'(1));
  assign out_free   = !out_valid_q || out_ready_i;

  // Frame store, real part in the upper half of each word.
  logic [2*SAMPLE_WIDTH-1:0] ram_rdata;
  logic                      issue;

  assign issue = (state_q == ST_ISSUE);

  dde_ram #(
    .Width (2 * SAMPLE_WIDTH),
    .Depth (MAX_POINTS)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (load_q),
    .wdata_i ({sample_real_i, sample_imag_i}),
    .re_i    (issue),
    .raddr_i (j_q),
    .rdata_o (ram_rdata)
  );

  // MAC pipeline: twiddle lookup, products, accumulate.
  logic                    va_q, fa_q, la_q;
  logic                    vb_q, fb_q, lb_q;
  logic signed [TwW-1:0]   cos_q, sin_q;
  logic signed [TwW-1:0]   cos_v, sin_v;
  logic signed [SAMPLE_WIDTH-1:0] xr, xi;
  logic signed [ProdW-1:0] prr_q, pii_q, prs_q, pic_q;
  logic signed [AccW-1:0]  acc_re_q, acc_im_q;
  logic signed [AccW-1:0]  base_re, base_im;

  always_comb begin
    cos_v = tw_cos(phase_q);
    sin_v = tw_cos(PhaseW'(phase_q + PhaseW'(3 * QuarterPts)));
    if (inverse_q) begin
      sin_v = -sin_v;
    end
  end

  assign xr      = signed'(ram_rdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
  assign xi      = signed'(ram_rdata[SAMPLE_WIDTH-1:0]);
  assign base_re = fb_q ? '0 : acc_re_q;
  assign base_im = fb_q ? '0 : acc_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      va_q   <= issue;
      vb_q   <= va_q;
      done_q <= vb_q && lb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fa_q  <= (j_q == '0);
    la_q  <= j_last;
    cos_q <= cos_v;
    sin_q <= sin_v;
    fb_q  <= fa_q;
    lb_q  <= la_q;
    prr_q <= ProdW'(xr) * ProdW'(cos_q);
    pii_q <= ProdW'(xi) * ProdW'(sin_q);
    prs_q <= ProdW'(xr) * ProdW'(sin_q);
    pic_q <= ProdW'(xi) * ProdW'(cos_q);
    if (vb_q) begin
      acc_re_q <= base_re + AccW'(prr_q) - AccW'(pii_q);
      acc_im_q <= base_im + AccW'(prs_q) + AccW'(pic_q);
    end
  end

  // Rounding half up, then saturation.
  logic signed [AccW-1:0] half;
  logic signed [AccW-1:0] rnd_re, rnd_im;
  logic signed [OutW-1:0] sat_re, sat_im;

  assign half   = AccW'(1) <<< (sh_amt - ShW'(1));
  assign rnd_re = (acc_re_q + half) >>> sh_amt;
  assign rnd_im = (acc_im_q + half) >>> sh_amt;

  always_comb begin
    if (rnd_re > SatHi) begin
      sat_re = OutW'(SatHi);
    end else if (rnd_re < SatLo) begin
      sat_re = OutW'(SatLo);
    end else begin
      sat_re = rnd_re[OutW-1:0];
    end
    if (rnd_im > SatHi) begin
      sat_im = OutW'(SatHi);
    end else if (rnd_im < SatLo) begin
      sat_im = OutW'(SatLo);
    end else begin
      sat_im = rnd_im[OutW-1:0];
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_q      <= '0;
      k_q         <= '0;
      j_q         <= '0;
      phase_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_idx_q   <= '0;
      out_re_q    <= '0;
      out_im_q    <= '0;
    end else begin
      // In the rounding phase a taken beat is always replaced by the next bin.
      if (out_valid_q && out_ready_i && state_q != ST_ROUND) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (in_fire) begin
            if (frame_done) begin
              load_q  <= '0;
              k_q     <= '0;
              j_q     <= '0;
              phase_q <= '0;
              step_q  <= '0;
              state_q <= ST_ISSUE;
            end else begin
              load_q <= load_q + AddrW'(1);
            end
          end
        end
        ST_ISSUE: begin
          if (j_last) begin
            j_q     <= '0;
            phase_q <= '0;
            state_q <= ST_DRAIN;
          end else begin
            j_q     <= j_q + AddrW'(1);
            phase_q <= phase_q + step_q;
          end
        end
        ST_DRAIN: begin
          if (done_q) begin
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_re_q    <= sat_re;
            out_im_q    <= sat_im;
            out_idx_q   <= BinIdxW'(k_q);
            out_last_q  <= k_last;
            if (k_last) begin
              k_q     <= '0;
              step_q  <= '0;
              state_q <= ST_LOAD;
            end else begin
              k_q     <= k_q + AddrW'(1);
              step_q  <= step_q + stride;
              state_q <= ST_ISSUE;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_real_o  = out_re_q;
  assign bin_imag_o  = out_im_q;
  assign bin_index_o = out_idx_q;
  assign last_bin_o  = out_last_q;

  // The accumulator completes only while the sequencer waits for it.
  `DDE_ASSERT_NOW(a_done_in_drain, clk_i, rst_ni, done_q, state_q == ST_DRAIN,
    "bin accumulation finished outside the drain phase")
  // Rounding sees a settled accumulator with the pipeline empty.
  `DDE_ASSERT_NOW(a_round_pipe_empty, clk_i, rst_ni, state_q == ST_ROUND,
    !va_q && !vb_q && !done_q, "rounding while the MAC pipeline is busy")
  // A new sample never lands while products of the frame are in flight.
  `DDE_ASSERT_NOW(a_load_pipe_idle, clk_i, rst_ni, in_fire, !va_q && !vb_q,
    "sample accepted while the MAC pipeline is busy")
  // Leaving the issue phase follows the last sample of the bin.
  `DDE_ASSERT_NEXT(a_issue_end, clk_i, rst_ni, issue && j_last,
    state_q == ST_DRAIN && va_q && la_q, "issue phase ended without the last sample")

endmodule
